// ===== sv/cda_pkg.sv =====
package cda_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned CountW = 16;
  // day plus a full count needs one bit more than the count
  localparam int unsigned AccW   = CountW + 1;

  localparam logic [DayW-1:0]   DAY_FIRST  = DayW'(1);
  localparam logic [MonthW-1:0] MONTH_JAN  = MonthW'(1);
  localparam logic [MonthW-1:0] MONTH_FEB  = MonthW'(2);
  localparam logic [MonthW-1:0] MONTH_APR  = MonthW'(4);
  localparam logic [MonthW-1:0] MONTH_JUN  = MonthW'(6);
  localparam logic [MonthW-1:0] MONTH_SEP  = MonthW'(9);
  localparam logic [MonthW-1:0] MONTH_NOV  = MonthW'(11);
  localparam logic [MonthW-1:0] MONTH_DEC  = MonthW'(12);
  localparam logic [YearW-1:0]  YEAR_RESET = YearW'(1900);

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_ADD     = 2'd1,
    OP_LOAD    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef struct packed {
    op_e               operation;
    logic [CountW-1:0] day_count;
    logic [DayW-1:0]   load_day;
    logic [MonthW-1:0] load_month;
    logic [YearW-1:0]  load_year;
  } in_t;

  typedef struct packed {
    logic [DayW-1:0]   day_out;
    logic [MonthW-1:0] month_out;
    logic [YearW-1:0]  year_out;
  } out_t;

  // result of the shared compare/subtract unit
  typedef struct packed {
    logic              over;
    logic [AccW-1:0]   diff;
    logic [DayW-1:0]   len;
  } step_t;

endpackage

// ===== sv/cda_leap_unit.sv =====
module cda_leap_unit import cda_pkg::*; (
  input  logic             clk_i,
  input  logic [YearW-1:0] year_i,
  output logic             leap_o
);

  // year / 100 by reciprocal: 5242 / 2^19 sits just below 1/100, so the
  // estimate is exact or one low over the whole 16-bit range
  localparam int unsigned RecipW = 13;
  localparam int unsigned Shift  = 19;
  localparam int unsigned ProdW  = YearW + RecipW;
  localparam int unsigned QuotW  = ProdW - Shift;
  localparam logic [RecipW-1:0] RECIP   = RecipW'(5242);
  localparam logic [YearW-1:0]  HUNDRED = YearW'(100);

  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot_q;
  logic [YearW-1:0] rem_wide;
  logic [7:0]       rem_est;
  logic             rem_big;
  logic [7:0]       rem;
  logic [QuotW-1:0] quot;

  assign prod = ProdW'(year_i) * ProdW'(RECIP);

  always_ff @(posedge clk_i) begin
    quot_q <= prod[ProdW-1:Shift];
  end

  always_comb begin
    rem_wide = year_i - YearW'(quot_q) * HUNDRED;
    rem_est  = rem_wide[7:0];
    rem_big  = rem_est >= 8'd100;
    rem      = rem_big ? rem_est - 8'd100 : rem_est;
    quot     = rem_big ? quot_q + QuotW'(1) : quot_q;
    // divisible by 4, and either not a century or a century divisible by 400
    leap_o   = (year_i[1:0] == 2'b00) && ((rem != 8'd0) || (quot[1:0] == 2'b00));
  end

endmodule

// ===== sv/cda_month_step.sv =====
module cda_month_step import cda_pkg::*; (
  input  logic [AccW-1:0]   acc_i,
  input  logic [MonthW-1:0] month_i,
  input  logic              leap_i,
  output step_t             step_o
);

  logic [DayW-1:0] len;

  always_comb begin
    unique case (month_i)
      MONTH_FEB: len = leap_i ? DayW'(29) : DayW'(28);
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DayW'(30);
      default: len = DayW'(31);
    endcase
  end

  assign step_o.len  = len;
  assign step_o.over = acc_i > AccW'(len);
  assign step_o.diff = acc_i - AccW'(len);

endmodule

// ===== sv/calendar_date_advance.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | in_i  (in_t)
// out     | output    | out_valid_o / out_ready_i | out_o (out_t)
//
// One item at a time; in_ready_o is high only while the sequencer is idle.
// Advance and add run one month per cycle through the shared length
// compare/subtract unit, except that each new year first waits for the leap
// recalculation. Load runs the leap recalculation, then the day clamp; code 3
// goes straight to the result stage.
// The result register lets the next item in while a result awaits transfer.
// Reset gives 1 January 1900.
module calendar_date_advance import cda_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_LEAP_A,
    S_LEAP_B,
    S_CLAMP,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [YearW-1:0]  year_q, year_d;
  logic              leap_q, leap_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic              clamp_q, clamp_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic  in_xfer;
  logic  leap_calc;
  step_t step;

  cda_leap_unit u_leap (
    .clk_i  (clk_i),
    .year_i (year_q),
    .leap_o (leap_calc)
  );

  cda_month_step u_step (
    .acc_i   (acc_q),
    .month_i (month_q),
    .leap_i  (leap_q),
    .step_o  (step)
  );

  assign in_ready_o  = state_q == S_IDLE;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    leap_d      = leap_q;
    acc_d       = acc_q;
    clamp_d     = clamp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_i.operation)
            OP_ADVANCE: begin
              acc_d   = AccW'(day_q) + AccW'(1);
              state_d = S_RUN;
            end
            OP_ADD: begin
              acc_d   = AccW'(day_q) + AccW'(in_i.day_count);
              state_d = S_RUN;
            end
            OP_LOAD: begin
              year_d  = in_i.load_year;
              if (in_i.load_month == '0) begin
                month_d = MONTH_JAN;
              end else if (in_i.load_month > MONTH_DEC) begin
                month_d = MONTH_DEC;
              end else begin
                month_d = in_i.load_month;
              end
              acc_d   = (in_i.load_day == '0) ? AccW'(DAY_FIRST) : AccW'(in_i.load_day);
              clamp_d = 1'b1;
              state_d = S_LEAP_A;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_RUN: begin
        if (step.over) begin
          acc_d = step.diff;
          if (month_q == MONTH_DEC) begin
            month_d = MONTH_JAN;
            year_d  = year_q + YearW'(1);
            clamp_d = 1'b0;
            state_d = S_LEAP_A;
          end else begin
            month_d = month_q + MonthW'(1);
          end
        end else begin
          day_d   = acc_q[DayW-1:0];
          state_d = S_OUT;
        end
      end
      // quotient register in the leap unit settles here
      S_LEAP_A: state_d = S_LEAP_B;
      S_LEAP_B: begin
        leap_d  = leap_calc;
        state_d = clamp_q ? S_CLAMP : S_RUN;
      end
      S_CLAMP: begin
        day_d   = step.over ? step.len : acc_q[DayW-1:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.day_out   = day_q;
          out_d.month_out = month_q;
          out_d.year_out  = year_q;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      day_q       <= DAY_FIRST;
      month_q     <= MONTH_JAN;
      year_q      <= YEAR_RESET;
      leap_q      <= 1'b0;
      clamp_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      day_q       <= day_d;
      month_q     <= month_d;
      year_q      <= year_d;
      leap_q      <= leap_d;
      clamp_q     <= clamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q != '0) && (month_q <= MONTH_DEC))
    else $error("month register out of range");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> day_q != '0)
    else $error("day register zero while idle");

  a_unused_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_i.operation == OP_NONE) |=> state_q == S_OUT && $stable(day_q))
    else $error("unused operation code changed the date");

  a_year_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN && step.over && month_q == MONTH_DEC
    |=> year_q == $past(year_q) + YearW'(1) && state_q == S_LEAP_A)
    else $error("year rollover without leap recalculation");

  a_result_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && (!out_valid_q || out_ready_i)
    |=> out_valid_q && out_q.day_out == $past(day_q) && out_q.year_out == $past(year_q))
    else $error("result register does not hold the kept date");

endmodule

// ===== tb/sv/calendar_date_advance_checker.sv =====
module calendar_date_advance_checker import cda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned ReportMax = 10;

  out_t date_now;
  out_t dates_due[$];
  out_t want;
  logic bad;

  function automatic logic is_leap(logic [YearW-1:0] y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(logic [MonthW-1:0] m, logic [YearW-1:0] y);
    case (m)
      MONTH_FEB: return is_leap(y) ? 29 : 28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
      default: return 31;
    endcase
  endfunction

  // date held after applying one command to the current date
  function automatic out_t date_after(in_t c, out_t d);
    out_t            r;
    int unsigned     acc;
    int unsigned     len;
    logic [MonthW-1:0] m;
    r = d;
    case (c.operation)
      OP_ADVANCE, OP_ADD: begin
        // one-day advance behaves exactly as adding a single day
        acc = r.day_out + ((c.operation == OP_ADVANCE) ? 1 : c.day_count);
        len = days_in_month(r.month_out, r.year_out);
        while (acc > len) begin
          acc = acc - len;
          if (r.month_out == MONTH_DEC) begin
            r.month_out = MONTH_JAN;
            r.year_out  = r.year_out + 1'b1;
          end else begin
            r.month_out = r.month_out + 1'b1;
          end
          len = days_in_month(r.month_out, r.year_out);
        end
        r.day_out = DayW'(acc);
      end
      OP_LOAD: begin
        m = c.load_month;
        if (m == '0) begin
          m = MONTH_JAN;
        end else if (m > MONTH_DEC) begin
          m = MONTH_DEC;
        end
        len = days_in_month(m, c.load_year);
        acc = c.load_day;
        if (acc == 0) begin
          acc = 1;
        end else if (acc > len) begin
          acc = len;
        end
        r.day_out   = DayW'(acc);
        r.month_out = m;
        r.year_out  = c.load_year;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_now     = {DAY_FIRST, MONTH_JAN, YEAR_RESET};
      dates_due.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      // older expectation first: a result never belongs to an item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (dates_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax) begin
            $display("%0t: unexpected result %0d/%0d/%0d", $time,
                     out_i.day_out, out_i.month_out, out_i.year_out);
          end
        end else begin
          want = dates_due.pop_front();
          bad  = (out_i.day_out != want.day_out) || (out_i.month_out != want.month_out) ||
                 (out_i.year_out != want.year_out);
          checked_o++;
          if (bad) begin
            fail_count_o++;
            if (fail_count_o <= ReportMax) begin
              $display("%0t: date mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d", $time,
                       want.day_out, want.month_out, want.year_out,
                       out_i.day_out, out_i.month_out, out_i.year_out);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        date_now = date_after(in_i, date_now);
        dates_due.push_back(date_now);
      end
      pending_o = dates_due.size();
    end
  end

endmodule

// ===== tb/sv/calendar_date_advance_tb.sv =====
module calendar_date_advance_tb;
  import cda_pkg::*;

  localparam int unsigned RandomItems   = 430;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned HoldAtItem    = 150;
  localparam int unsigned SettleCycles  = 50;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int unsigned fails;
  int unsigned pending;
  int unsigned checked;

  int unsigned op_seen [4];
  int unsigned in_calm  = 0;
  int unsigned out_calm = 0;
  int unsigned idle_cycles = 0;
  logic        hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calendar_date_advance uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  calendar_date_advance_checker date_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_data),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // random gap with occasional stretches of back-to-back transfers
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // fields the operation ignores are filled with noise
  function automatic in_t cmd(op_e op, int unsigned count, int unsigned d, int unsigned m,
                              int unsigned y);
    in_t c;
    c.operation  = op;
    c.day_count  = CountW'($urandom);
    c.load_day   = DayW'($urandom);
    c.load_month = MonthW'($urandom);
    c.load_year  = YearW'($urandom);
    if (op == OP_ADD) begin
      c.day_count = CountW'(count);
    end
    if (op == OP_LOAD) begin
      c.load_day   = DayW'(d);
      c.load_month = MonthW'(m);
      c.load_year  = YearW'(y);
    end
    return c;
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 7))
      0: return 65535;
      1: return 0;
      2: return 1900;
      3: return 2000;
      4: return 2100;
      5: return $urandom_range(1990, 2030);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic in_t random_cmd();
    int unsigned pick;
    int unsigned count;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      return cmd(OP_ADVANCE, 0, 0, 0, 0);
    end
    if (pick < 65) begin
      // mostly short hops across month ends, a few very long ones
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: count = $urandom_range(0, 62);
        6, 7:             count = $urandom_range(0, 800);
        8:                count = $urandom_range(0, 6000);
        default:          count = $urandom_range(0, 65535);
      endcase
      return cmd(OP_ADD, count, 0, 0, 0);
    end
    if (pick < 90) begin
      if ($urandom_range(0, 4) == 0) begin
        return cmd(OP_LOAD, 0, $urandom_range(0, 31), $urandom_range(0, 15), pick_year());
      end
      return cmd(OP_LOAD, 0, $urandom_range(25, 31), $urandom_range(1, 12), pick_year());
    end
    return cmd(OP_NONE, 0, 0, 0, 0);
  endfunction

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic offer(input in_t item);
    int unsigned gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    op_seen[item.operation]++;
  endtask

  initial begin
    int unsigned gap;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        // long back-pressure so the block fills and stalls its input
        hold_req = 1'b0;
        gap = HoldCycles;
      end else begin
        gap = draw_gap(out_calm);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no transfer for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(cmd(OP_NONE, 0, 0, 0, 0));
    offer(cmd(OP_ADVANCE, 0, 0, 0, 0));
    offer(cmd(OP_ADD, 0, 0, 0, 0));
    offer(cmd(OP_ADD, 29, 0, 0, 0));
    offer(cmd(OP_LOAD, 0, 28, 2, 1900));
    offer(cmd(OP_ADVANCE, 0, 0, 0, 0));
    offer(cmd(OP_LOAD, 0, 28, 2, 2000));
    offer(cmd(OP_ADVANCE, 0, 0, 0, 0));
    offer(cmd(OP_ADVANCE, 0, 0, 0, 0));
    offer(cmd(OP_LOAD, 0, 31, 2, 2100));
    offer(cmd(OP_LOAD, 0, 30, 2, 2024));
    offer(cmd(OP_LOAD, 0, 0, 0, 2023));
    offer(cmd(OP_LOAD, 0, 31, 15, 65535));
    offer(cmd(OP_ADVANCE, 0, 0, 0, 0));
    offer(cmd(OP_LOAD, 0, 28, 2, 0));
    offer(cmd(OP_ADVANCE, 0, 0, 0, 0));
    offer(cmd(OP_LOAD, 0, 31, 4, 2023));
    offer(cmd(OP_LOAD, 0, 31, 12, 65535));
    offer(cmd(OP_ADD, 65535, 0, 0, 0));
    offer(cmd(OP_LOAD, 0, 31, 1, 2023));
    offer(cmd(OP_ADD, 1, 0, 0, 0));
    offer(cmd(OP_LOAD, 0, 31, 3, 1999));
    offer(cmd(OP_NONE, 0, 0, 0, 0));
    offer(cmd(OP_ADD, 65535, 0, 0, 0));

    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == HoldAtItem) begin
        hold_req = 1'b1;
      end
      offer(random_cmd());
    end
    in_valid <= 1'b0;

    // sample away from the rising edge so the last transfer is already counted
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("items in: %0d advance, %0d add, %0d load, %0d unused code",
             op_seen[OP_ADVANCE], op_seen[OP_ADD], op_seen[OP_LOAD], op_seen[OP_NONE]);
    $display("dates checked: %0d, failures: %0d, still awaited: %0d", checked, fails, pending);
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
